### sv/icr_pkg.sv
// ----------------------------------------------------------------------------
// icr_pkg
// Types, codes and helpers shared by the interrupt controller register block.
// ----------------------------------------------------------------------------
`default_nettype none

package icr_pkg;

	typedef enum logic [2:0] {
		ACT_WR_CMD  = 3'd0,
		ACT_WR_DATA = 3'd1,
		ACT_RD_CMD  = 3'd2,
		ACT_RD_DATA = 3'd3,
		ACT_SAMPLE  = 3'd4,
		ACT_ACK     = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		PH_READY = 2'd0,
		PH_ICW2  = 2'd1,
		PH_ICW3  = 2'd2,
		PH_ICW4  = 2'd3
	} phase_t;

	// command byte decode
	localparam int unsigned ICW1_BIT  = 4;
	localparam int unsigned OCW3_BIT  = 3;
	localparam logic [2:0] OCW2_NS_EOI = 3'b001;
	localparam logic [2:0] OCW2_SP_EOI = 3'b011;
	localparam logic [7:0] PREV_INIT   = 8'hFF;

	typedef struct packed {
		logic [7:0] read_data;
		logic       int_pending;
		logic [7:0] vector;
		logic       vector_valid;
	} result_t;

	// index of lowest set bit, 8 when none
	function automatic logic [3:0] lowest_bit(input logic [7:0] v);
		logic [3:0] r;
		r = 4'd8;
		for (int i = 7; i >= 0; i--) begin
			if (v[i]) r = 4'(i);
		end
		return r;
	endfunction

	// best unmasked request that outranks the in-service set, 8 when none
	function automatic logic [3:0] eligible(input logic [7:0] req, input logic [7:0] mask,
			input logic [7:0] svc);
		logic [3:0] r;
		logic [3:0] s;
		r = lowest_bit(req & ~mask);
		s = lowest_bit(svc);
		return (r < s) ? r : 4'd8;
	endfunction

endpackage

`default_nettype wire

### sv/icr_core.sv
// ----------------------------------------------------------------------------
// icr_core
// Controller state and the combinational decode of one word.
// ----------------------------------------------------------------------------
`default_nettype none

module icr_core (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic [2:0]      action,
	input  wire logic [7:0]      port_data,
	input  wire logic [7:0]      irq_lines,
	output icr_pkg::result_t     result
);

	icr_pkg::phase_t phase_q, phase_d;
	logic       need_icw4_q, need_icw4_d;
	logic       single_q, single_d;
	logic       level_q, level_d;
	logic [4:0] base_q, base_d;
	logic [7:0] cascade_q, cascade_d;
	logic [7:0] mode_q, mode_d;
	logic [7:0] mask_q, mask_d;
	logic [7:0] req_q, req_d;
	logic [7:0] svc_q, svc_d;
	logic       rsel_q, rsel_d;
	logic [7:0] prev_q, prev_d;

	always_comb begin
		logic [3:0] b;
		logic [3:0] lvl;
		logic [3:0] nxt;
		phase_d     = phase_q;
		need_icw4_d = need_icw4_q;
		single_d    = single_q;
		level_d     = level_q;
		base_d      = base_q;
		cascade_d   = cascade_q;
		mode_d      = mode_q;
		mask_d      = mask_q;
		req_d       = req_q;
		svc_d       = svc_q;
		rsel_d      = rsel_q;
		prev_d      = prev_q;
		result      = '0;
		b   = icr_pkg::lowest_bit(svc_q);
		lvl = icr_pkg::eligible(req_q, mask_q, svc_q);
		case (icr_pkg::action_t'(action))
			icr_pkg::ACT_WR_CMD: begin
				if (port_data[icr_pkg::ICW1_BIT]) begin
					need_icw4_d = port_data[0];
					single_d    = port_data[1];
					level_d     = port_data[3];
					mask_d      = '0;
					req_d       = '0;
					svc_d       = '0;
					mode_d      = '0;
					rsel_d      = 1'b0;
					prev_d      = icr_pkg::PREV_INIT;
					phase_d     = icr_pkg::PH_ICW2;
				end else if (port_data[icr_pkg::OCW3_BIT]) begin
					if (port_data[1]) rsel_d = port_data[0];
				end else if (port_data[7:5] == icr_pkg::OCW2_NS_EOI) begin
					if (!b[3]) svc_d[b[2:0]] = 1'b0;
				end else if (port_data[7:5] == icr_pkg::OCW2_SP_EOI) begin
					svc_d[port_data[2:0]] = 1'b0;
				end
			end
			icr_pkg::ACT_WR_DATA: begin
				case (phase_q)
					icr_pkg::PH_ICW2: begin
						base_d = port_data[7:3];
						if (!single_q)     phase_d = icr_pkg::PH_ICW3;
						else if (need_icw4_q) phase_d = icr_pkg::PH_ICW4;
						else               phase_d = icr_pkg::PH_READY;
					end
					icr_pkg::PH_ICW3: begin
						cascade_d = port_data;
						phase_d   = need_icw4_q ? icr_pkg::PH_ICW4 : icr_pkg::PH_READY;
					end
					icr_pkg::PH_ICW4: begin
						mode_d  = port_data;
						phase_d = icr_pkg::PH_READY;
					end
					default: mask_d = port_data;
				endcase
			end
			icr_pkg::ACT_RD_CMD:  result.read_data = rsel_q ? svc_q : req_q;
			icr_pkg::ACT_RD_DATA: result.read_data = mask_q;
			icr_pkg::ACT_SAMPLE: begin
				req_d  = level_q ? irq_lines : (req_q | (irq_lines & ~prev_q));
				prev_d = irq_lines;
			end
			icr_pkg::ACT_ACK: begin
				if (!lvl[3]) begin
					svc_d[lvl[2:0]]     = 1'b1;
					req_d[lvl[2:0]]     = 1'b0;
					result.vector       = {base_q, lvl[2:0]};
					result.vector_valid = 1'b1;
				end
			end
			default: ;
		endcase
		nxt = icr_pkg::eligible(req_d, mask_d, svc_d);
		result.int_pending = !nxt[3];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= icr_pkg::PH_READY;
			need_icw4_q <= 1'b0;
			single_q    <= 1'b0;
			level_q     <= 1'b0;
			base_q      <= '0;
			cascade_q   <= '0;
			mode_q      <= '0;
			mask_q      <= '0;
			req_q       <= '0;
			svc_q       <= '0;
			rsel_q      <= 1'b0;
			prev_q      <= '0;
		end else if (en) begin
			phase_q     <= phase_d;
			need_icw4_q <= need_icw4_d;
			single_q    <= single_d;
			level_q     <= level_d;
			base_q      <= base_d;
			cascade_q   <= cascade_d;
			mode_q      <= mode_d;
			mask_q      <= mask_d;
			req_q       <= req_d;
			svc_q       <= svc_d;
			rsel_q      <= rsel_d;
			prev_q      <= prev_d;
		end
	end

endmodule

`default_nettype wire

### sv/interrupt_controller_regs_top.sv
// ----------------------------------------------------------------------------
// interrupt_controller_regs_top
// 8259A-style interrupt controller register block on a valid/ready stream.
// ----------------------------------------------------------------------------
// channel | handshake           | payload
// input   | in_valid, in_ready   | action, port_data, irq_lines
// output  | out_valid, out_ready | read_data, int_pending, vector, vector_valid
//
// One word per cycle sustained while out_ready holds; each word passes an input
// register and a result register, state updated as a word leaves the input register.
// A stalled result holds in the result register; the input register keeps
// taking words until both stages are full.
// arst_n clears both stages and all controller state.
// ----------------------------------------------------------------------------
`default_nettype none

module interrupt_controller_regs_top (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output      logic       in_ready,
	input  wire logic [2:0] action,
	input  wire logic [7:0] port_data,
	input  wire logic [7:0] irq_lines,
	output      logic       out_valid,
	input  wire logic       out_ready,
	output      logic [7:0] read_data,
	output      logic       int_pending,
	output      logic [7:0] vector,
	output      logic       vector_valid
);

	logic             valid_s1;
	logic [2:0]       action_s1;
	logic [7:0]       data_s1;
	logic [7:0]       lines_s1;
	logic             valid_s2;
	icr_pkg::result_t result_s2;
	icr_pkg::result_t core_res;
	logic             adv;

	assign adv      = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || adv;

	icr_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (valid_s1 && adv),
		.action    (action_s1),
		.port_data (data_s1),
		.irq_lines (lines_s1),
		.result    (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) valid_s1 <= in_valid;
			if (adv)      valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			action_s1 <= action;
			data_s1   <= port_data;
			lines_s1  <= irq_lines;
		end
		if (adv && valid_s1) result_s2 <= core_res;
	end

	assign out_valid    = valid_s2;
	assign read_data    = result_s2.read_data;
	assign int_pending  = result_s2.int_pending;
	assign vector       = result_s2.vector;
	assign vector_valid = result_s2.vector_valid;

endmodule

`default_nettype wire

### sv/icr_checker.sv
// ----------------------------------------------------------------------------
// icr_checker
// Port-level checks for the interrupt controller register block.
// ----------------------------------------------------------------------------
`default_nettype none

module icr_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] read_data,
	input wire logic       int_pending,
	input wire logic [7:0] vector,
	input wire logic       vector_valid
);

	// stalled word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(vector)
			&& $stable(vector_valid) && $stable(int_pending))
		else $error("result word changed while stalled");

	// no vector without a successful acknowledge
	a_vec_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !vector_valid |-> vector == 8'd0)
		else $error("vector nonzero without vector_valid");

	// a read and an acknowledge never share a word
	a_rd_ack_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && vector_valid |-> read_data == 8'd0)
		else $error("read data on an acknowledge word");

endmodule

bind interrupt_controller_regs_top icr_checker u_icr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.read_data    (read_data),
	.int_pending  (int_pending),
	.vector       (vector),
	.vector_valid (vector_valid)
);

`default_nettype wire

### tb/interrupt_controller_regs_top_test.sv
// ----------------------------------------------------------------------------
// interrupt_controller_regs_top_test
// Self-checking bench for the interrupt controller register block. A table of
// directed words covers initialisation, edges, EOIs and register reads; then
// random words, mostly normal traffic and some complete initialisation
// sequences, are checked against a cycle-free model of the controller state.
// ----------------------------------------------------------------------------

module interrupt_controller_regs_top_test;

	import icr_pkg::*;

	typedef struct {
		action_t    act;
		logic [7:0] data;
		logic [7:0] lines;
		bit         fixed;
		result_t    want;
	} probe_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	action_t    action;
	logic [7:0] port_data;
	logic [7:0] irq_lines;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] read_data;
	logic       int_pending;
	logic [7:0] vector;
	logic       vector_valid;

	// controller state as the bench sees it
	phase_t     init_step  = PH_READY;
	bit         icw4_due   = 1'b0;
	bit         solo       = 1'b0;
	bit         level_trig = 1'b0;
	logic [4:0] vec_base   = '0;
	logic [7:0] casc_byte  = '0;
	logic [7:0] mode_byte  = '0;
	logic [7:0] imr        = '0;
	logic [7:0] irr        = '0;
	logic [7:0] isr        = '0;
	logic [7:0] lines_seen = '0;
	bit         read_isr   = 1'b0;

	result_t results_due[$];
	probe_t  directed_rows[$];
	int      errors    = 0;
	int      got_count = 0;
	int      sent      = 0;
	bit      calm      = 1'b0;
	bit      held      = 1'b0;

	interrupt_controller_regs_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.port_data    (port_data),
		.irq_lines    (irq_lines),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.read_data    (read_data),
		.int_pending  (int_pending),
		.vector       (vector),
		.vector_valid (vector_valid)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int first_set(input logic [7:0] v);
		for (int i = 0; i < 8; i++) begin
			if (v[i]) return i;
		end
		return 8;
	endfunction

	function automatic int grant_level();
		int r;
		int s;
		r = first_set(irr & ~imr);
		s = first_set(isr);
		return (r < s) ? r : 8;
	endfunction

	task automatic pic_step(input action_t a, input logic [7:0] d, input logic [7:0] l,
			output result_t r);
		int lvl;
		r = '0;
		case (a)
			ACT_WR_CMD: begin
				if (d[ICW1_BIT]) begin
					icw4_due   = d[0];
					solo       = d[1];
					level_trig = d[3];
					imr        = '0;
					irr        = '0;
					isr        = '0;
					mode_byte  = '0;
					read_isr   = 1'b0;
					lines_seen = PREV_INIT;
					init_step  = PH_ICW2;
				end else if (d[OCW3_BIT]) begin
					if (d[1]) read_isr = d[0];
				end else if (d[7:5] == OCW2_NS_EOI) begin
					lvl = first_set(isr);
					if (lvl < 8) isr[lvl] = 1'b0;
				end else if (d[7:5] == OCW2_SP_EOI) begin
					isr[d[2:0]] = 1'b0;
				end
			end
			ACT_WR_DATA: begin
				case (init_step)
					PH_ICW2: begin
						vec_base = d[7:3];
						if (!solo) init_step = PH_ICW3;
						else init_step = icw4_due ? PH_ICW4 : PH_READY;
					end
					PH_ICW3: begin
						casc_byte = d;
						init_step = icw4_due ? PH_ICW4 : PH_READY;
					end
					PH_ICW4: begin
						mode_byte = d;
						init_step = PH_READY;
					end
					default: imr = d;
				endcase
			end
			ACT_RD_CMD: r.read_data = read_isr ? isr : irr;
			ACT_RD_DATA: r.read_data = imr;
			ACT_SAMPLE: begin
				if (level_trig) irr = l;
				else irr = irr | (l & ~lines_seen);
				lines_seen = l;
			end
			ACT_ACK: begin
				lvl = grant_level();
				if (lvl < 8) begin
					isr[lvl] = 1'b1;
					irr[lvl] = 1'b0;
					r.vector = {vec_base, 3'(lvl)};
					r.vector_valid = 1'b1;
				end
			end
			default: ;
		endcase
		r.int_pending = grant_level() < 8;
	endtask

	task automatic flag_mismatch(input string field, input logic [7:0] seen,
			input logic [7:0] want);
		if (errors < 50)
			$display("mismatch on %s at word %0d: got %02h, want %02h",
				field, got_count, seen, want);
		errors++;
	endtask

	// one word onto the input; expectation queued on acceptance
	task automatic offer(input action_t a, input logic [7:0] d, input logic [7:0] l,
			input bit fixed, input result_t want);
		result_t r;
		@(negedge clk);
		while (!calm && $urandom_range(99) < 6) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		action    <= a;
		port_data <= d;
		irq_lines <= l;
		do @(posedge clk); while (!in_ready);
		pic_step(a, d, l, r);
		results_due.push_back(fixed ? want : r);
		sent++;
	endtask

	function automatic void add_row(input action_t a, input logic [7:0] d,
			input logic [7:0] l, input bit fixed, input result_t want);
		directed_rows.push_back('{a, d, l, fixed, want});
	endfunction

	task automatic random_op();
		int         pick;
		logic [7:0] d;
		logic [7:0] l;
		pick = $urandom_range(99);
		d = 8'($urandom);
		l = 8'($urandom);
		if (pick < 30) begin
			offer(ACT_SAMPLE, d, l, 1'b0, '0);
		end else if (pick < 50) begin
			offer(ACT_ACK, d, l, 1'b0, '0);
		end else if (pick < 62) begin
			offer(ACT_RD_CMD, d, l, 1'b0, '0);
		end else if (pick < 70) begin
			offer(ACT_RD_DATA, d, l, 1'b0, '0);
		end else if (pick < 80) begin
			offer(ACT_WR_DATA, d & 8'($urandom), l, 1'b0, '0);
		end else begin
			case ($urandom_range(3))
				0: d = {OCW2_NS_EOI, 2'b00, d[2:0]};
				1: d = {OCW2_SP_EOI, 2'b00, d[2:0]};
				2: d = {d[7:5], 2'b01, d[2:0]};
				default: d[ICW1_BIT] = 1'b0;
			endcase
			offer(ACT_WR_CMD, d, l, 1'b0, '0);
		end
	endtask

	// receiving side: random stalls plus one long hold-off
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && got_count >= 120) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (80) @(negedge clk);
			end
			out_ready <= calm || ($urandom_range(99) >= 6);
		end
	end

	always @(posedge clk) begin
		result_t e;
		if (arst_n && out_valid && out_ready) begin
			if (results_due.size() == 0) begin
				flag_mismatch("word with none due", read_data, 8'h00);
			end else begin
				e = results_due.pop_front();
				if (read_data !== e.read_data)
					flag_mismatch("read_data", read_data, e.read_data);
				if (int_pending !== e.int_pending)
					flag_mismatch("int_pending", 8'(int_pending), 8'(e.int_pending));
				if (vector !== e.vector)
					flag_mismatch("vector", vector, e.vector);
				if (vector_valid !== e.vector_valid)
					flag_mismatch("vector_valid", 8'(vector_valid), 8'(e.vector_valid));
			end
			got_count++;
		end
	end

	initial begin
		#400000;
		$display("interrupt_controller_regs_top verification failed");
		$finish;
	end

	initial begin
		logic [7:0] icw1;
		int         steps;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		action    = ACT_WR_CMD;
		port_data = 8'h00;
		irq_lines = 8'h00;

		add_row(ACT_RD_DATA, 8'h00, 8'h00, 1'b1, {8'h00, 1'b0, 8'h00, 1'b0});
		add_row(ACT_RD_CMD,  8'h00, 8'h00, 1'b1, {8'h00, 1'b0, 8'h00, 1'b0});
		add_row(ACT_ACK,     8'hFF, 8'hFF, 1'b1, {8'h00, 1'b0, 8'h00, 1'b0});
		add_row(ACT_WR_CMD,  8'h11, 8'h00, 1'b1, {8'h00, 1'b0, 8'h00, 1'b0});
		add_row(ACT_SAMPLE,  8'h00, 8'hFF, 1'b0, '0);
		add_row(ACT_WR_DATA, 8'hFF, 8'h00, 1'b0, '0);
		add_row(ACT_WR_DATA, 8'h00, 8'h00, 1'b0, '0);
		add_row(ACT_WR_DATA, 8'hFF, 8'h00, 1'b0, '0);
		add_row(ACT_RD_DATA, 8'h00, 8'h00, 1'b1, {8'h00, 1'b0, 8'h00, 1'b0});
		add_row(ACT_SAMPLE,  8'h00, 8'h00, 1'b0, '0);
		add_row(ACT_SAMPLE,  8'h00, 8'hFF, 1'b0, '0);
		add_row(ACT_RD_CMD,  8'h00, 8'h00, 1'b0, '0);
		add_row(ACT_ACK,     8'h00, 8'h00, 1'b1, {8'h00, 1'b0, 8'hF8, 1'b1});
		add_row(ACT_ACK,     8'h00, 8'h00, 1'b1, {8'h00, 1'b0, 8'h00, 1'b0});
		add_row(ACT_WR_CMD,  8'h0B, 8'h00, 1'b0, '0);
		add_row(ACT_RD_CMD,  8'h00, 8'h00, 1'b0, '0);
		add_row(ACT_WR_CMD,  8'h20, 8'h00, 1'b0, '0);
		add_row(ACT_WR_DATA, 8'h02, 8'h00, 1'b0, '0);
		add_row(ACT_ACK,     8'h00, 8'h00, 1'b0, '0);
		add_row(ACT_WR_CMD,  8'h62, 8'h00, 1'b0, '0);
		add_row(ACT_WR_CMD,  8'h0A, 8'h00, 1'b0, '0);
		add_row(ACT_RD_CMD,  8'h00, 8'h00, 1'b0, '0);
		// level mode, single, ICW4; acknowledge before the sequence ends
		add_row(ACT_WR_CMD,  8'h1B, 8'h00, 1'b0, '0);
		add_row(ACT_SAMPLE,  8'h00, 8'h80, 1'b0, '0);
		add_row(ACT_ACK,     8'h00, 8'h00, 1'b0, '0);
		add_row(ACT_WR_DATA, 8'h00, 8'h00, 1'b0, '0);
		add_row(ACT_WR_DATA, 8'h03, 8'h00, 1'b0, '0);
		add_row(ACT_WR_DATA, 8'hFF, 8'h00, 1'b0, '0);
		add_row(ACT_RD_DATA, 8'h00, 8'h00, 1'b0, '0);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			offer(directed_rows[i].act, directed_rows[i].data, directed_rows[i].lines,
				directed_rows[i].fixed, directed_rows[i].want);

		while (sent < directed_rows.size() + 550) begin
			calm = (sent >= 280 && sent < 380);
			if ($urandom_range(99) < 8) begin
				icw1 = 8'($urandom);
				icw1[ICW1_BIT] = 1'b1;
				offer(ACT_WR_CMD, icw1, 8'($urandom), 1'b0, '0);
				steps = 1 + (icw1[1] ? 0 : 1) + (icw1[0] ? 1 : 0);
				repeat (steps) begin
					if ($urandom_range(9) == 0) random_op();
					offer(ACT_WR_DATA, 8'($urandom), 8'($urandom), 1'b0, '0);
				end
			end else begin
				random_op();
			end
		end
		calm = 1'b0;
		@(negedge clk);
		in_valid <= 1'b0;

		while (results_due.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
		if (errors == 0) begin
			$display("interrupt_controller_regs_top verification clean");
		end else begin
			$display("interrupt_controller_regs_top verification failed");
		end
		$finish;
	end

endmodule

### files.f
sv/icr_pkg.sv
sv/icr_core.sv
sv/interrupt_controller_regs_top.sv
sv/icr_checker.sv
tb/interrupt_controller_regs_top_test.sv
